// ===== src/wpbfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpbfe_pkg
// Shared types and constants of the worm-like-chain plus power-law bond unit.
// ----------------------------------------------------------------------------
package wpbfe_pkg;

    localparam int NUM_TYPES_DEF = 2;
    localparam int COEF_W        = 32;
    localparam int LEN_W         = 40;
    localparam int RES_W         = 48;
    localparam int FLD_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = COEF_W;

    typedef enum logic [FLD_W-1:0] {
        FLD_STIFFNESS   = 2'd0,
        FLD_REST_LENGTH = 2'd1,
        FLD_EXT_RATIO   = 2'd2,
        FLD_REPULSION   = 2'd3
    } field_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [COEF_W-1:0] REST_LENGTH_RST = 32'h0001_0000;
    localparam logic [COEF_W-1:0] EXT_RATIO_RST   = 32'd144179;

    localparam logic [RES_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [COEF_W-1:0] stiffness;
        logic [COEF_W-1:0] rest_length;
        logic [COEF_W-1:0] extension_ratio;
        logic [COEF_W-1:0] repulsion;
    } coef_t;

    typedef struct packed {
        logic             bond_type;
        logic [LEN_W-1:0] squared_length;
    } in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] force_over_length;
        logic signed [RES_W-1:0] bond_energy;
        status_t                 status;
    } out_t;

endpackage
`default_nettype wire

// ===== src/wlc_pow_bond_force_energy_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlc_pow_bond_force_energy_top
// Worm-like-chain plus power-law bond: force over length and bond energy.
// ----------------------------------------------------------------------------
// Takes one bond per clock while the result side does not stall, and presents its
// force over length and energy through an input register followed by 185 datapath
// stages, the last of which drives m_data. The latency is set by the square
// root and the restoring dividers, which each resolve one quotient bit per
// pipeline stage; the longest chain is the inverse-square divide (71 bits)
// followed by the force divide (48 bits).
// All stages advance together; a stall on the result side holds the whole
// pipeline, and s_ready drops only while a result waits untaken.
// Coefficients are to be written through the cfg port only while no bond is in flight; the block does not enforce this.
module wlc_pow_bond_force_energy_top #(
    parameter int NUM_TYPES = wpbfe_pkg::NUM_TYPES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wpbfe_pkg::in_t                        s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output wpbfe_pkg::out_t                       m_data,
    input  wire logic                             cfg_we,
    input  wire logic [wpbfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wpbfe_pkg::CFG_DATA_W-1:0] cfg_data
);

    wpbfe_pkg::coef_t coef_reg [NUM_TYPES];
    logic             en;

    always_ff @(posedge aclk) begin
        for (int t = 0; t < NUM_TYPES; t++) begin
            if (!aresetn) begin
                coef_reg[t].stiffness       <= '0;
                coef_reg[t].rest_length     <= wpbfe_pkg::REST_LENGTH_RST;
                coef_reg[t].extension_ratio <= wpbfe_pkg::EXT_RATIO_RST;
                coef_reg[t].repulsion       <= '0;
            end else if (cfg_we &&
                         (int'(cfg_index[wpbfe_pkg::CFG_IDX_W-1:wpbfe_pkg::FLD_W]) == t)) begin
                case (wpbfe_pkg::field_t'(cfg_index[wpbfe_pkg::FLD_W-1:0]))
                    wpbfe_pkg::FLD_STIFFNESS:   coef_reg[t].stiffness       <= cfg_data;
                    wpbfe_pkg::FLD_REST_LENGTH: coef_reg[t].rest_length     <= cfg_data;
                    wpbfe_pkg::FLD_EXT_RATIO:   coef_reg[t].extension_ratio <= cfg_data;
                    wpbfe_pkg::FLD_REPULSION:   coef_reg[t].repulsion       <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // whole pipeline moves unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    wpbfe_pipe #(
        .NUM_TYPES (NUM_TYPES)
    ) u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .coefs     (coef_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == wpbfe_pkg::ST_ZERO |->
            m_data.force_over_length == '0 && m_data.bond_energy == wpbfe_pkg::POS_MAX)
        else $error("zero length result malformed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == wpbfe_pkg::ST_RANGE |->
            m_data.force_over_length == wpbfe_pkg::NEG_MAG &&
            m_data.bond_energy == wpbfe_pkg::POS_MAX)
        else $error("out of range result malformed");

    a_energy_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.bond_energy[wpbfe_pkg::RES_W-1])
        else $error("negative bond energy");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result held");

endmodule
`default_nettype wire

// ===== src/wpbfe_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpbfe_pipe
// Datapath pipeline: square root, ratio, inverse square, force and energy
// divisions, one quotient bit per stage, all advanced by a common enable.
// ----------------------------------------------------------------------------
module wpbfe_pipe #(
    parameter int NUM_TYPES = wpbfe_pkg::NUM_TYPES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wpbfe_pkg::in_t        in_data,
    input  wpbfe_pkg::coef_t      coefs [NUM_TYPES],
    output logic                  out_valid,
    output wpbfe_pkg::out_t       out_data
);

    // step schedule
    localparam int SQ0     = 0;
    localparam int SQ_N    = 32;
    localparam int PF0     = 0;
    localparam int PF_N    = 64;
    localparam int MUL_R   = 32;
    localparam int KP2_SET = 32;
    localparam int KP2_0   = 33;
    localparam int KP2_N   = 47;
    localparam int DA_SET  = 33;
    localparam int DA0     = 34;
    localparam int DA_N    = 24;
    localparam int D1      = 58;
    localparam int D2      = 59;
    localparam int KG_MUL  = 60;
    localparam int INV0    = 60;
    localparam int INV_N   = 71;
    localparam int KG_SUM  = 61;
    localparam int E1_SET  = 62;
    localparam int E1_0    = 63;
    localparam int E1_N    = 47;
    localparam int ESUM    = 110;
    localparam int TT      = 131;
    localparam int TK_MUL  = 132;
    localparam int W_SUM   = 133;
    localparam int NUM     = 134;
    localparam int FN_SET  = 135;
    localparam int FN0     = 136;
    localparam int FN_N    = 48;
    localparam int FIN     = 184;
    localparam int NSTEP   = 185;

    localparam logic [24:0] ONE_Q24   = 25'h100_0000;
    localparam logic [25:0] THREE_Q24 = 26'h300_0000;
    localparam logic [70:0] QUARTER   = 71'h40_0000;

    typedef struct packed {
        logic                 bond_type;
        logic [39:0]          s;
        logic                 zero;
        logic [63:0]          sq_x;
        logic [34:0]          sq_rem;
        logic [31:0]          r;
        logic [63:0]          pf_n;
        logic [40:0]          pf_rem;
        logic [63:0]          pf_q;
        logic [63:0]          prod_a;
        logic [63:0]          kr;
        logic [46:0]          kp2_n;
        logic [32:0]          kp2_rem;
        logic [46:0]          kp2_q;
        logic                 kp2_ovf;
        logic [23:0]          da_n;
        logic [32:0]          da_rem;
        logic [23:0]          a;
        logic                 a_sat;
        logic [24:0]          d;
        logic [25:0]          gm;
        logic [49:0]          dd;
        logic [49:0]          g;
        logic [56:0]          kg0;
        logic [56:0]          kg1;
        logic [56:0]          kg2;
        logic [56:0]          kg3;
        logic [71:0]          e1_n;
        logic [46:0]          e1_s;
        logic [25:0]          e1_rem;
        logic [46:0]          e1_q;
        logic                 e1_ovf;
        logic [47:0]          energy;
        logic [49:0]          inv_rem;
        logic [70:0]          inv_q;
        logic [70:0]          tt;
        logic [55:0]          tk0;
        logic [55:0]          tk1;
        logic [55:0]          tk2;
        logic [87:0]          w;
        logic                 fn_neg;
        logic [87:0]          num;
        logic [47:0]          fn_s;
        logic [32:0]          fn_rem;
        logic [47:0]          fn_q;
        logic                 fn_ovf;
        logic [47:0]          force_q;
        wpbfe_pkg::status_t   status;
    } pipe_t;

    pipe_t            stage_reg  [NSTEP+1];
    pipe_t            stage_next [NSTEP];
    logic             vld_reg    [NSTEP+1];
    pipe_t            cap_next;
    wpbfe_pkg::coef_t cf_in;

    // types beyond the configured count fall back to the last one
    function automatic logic tsel(input logic t);
        return (NUM_TYPES > 1) ? t : 1'b0;
    endfunction

    assign cf_in = coefs[tsel(in_data.bond_type)];

    always_comb begin
        cap_next           = '0;
        cap_next.bond_type = in_data.bond_type;
        cap_next.s         = in_data.squared_length;
        cap_next.zero      = (in_data.squared_length == '0);
        cap_next.sq_x      = {in_data.squared_length, 24'd0};
        cap_next.pf_n      = {cf_in.repulsion, 32'd0};
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        pipe_t            cur;
        pipe_t            nxt;
        wpbfe_pkg::coef_t cf;
        logic [34:0]      sq_sh;
        logic [34:0]      sq_try;
        logic             sq_ge;
        logic [40:0]      pf_sh;
        logic             pf_ge;
        logic [32:0]      kp2_sh;
        logic             kp2_ge;
        logic [32:0]      da_sh;
        logic             da_ge;
        logic [49:0]      inv_sh;
        logic             inv_ge;
        logic [25:0]      e1_sh;
        logic             e1_ge;
        logic [32:0]      fn_sh;
        logic             fn_ge;
        logic [113:0]     kg_sum;
        logic [103:0]     tk_sum;
        logic [47:0]      e_sum;
        logic [87:0]      pf_x;
        logic [47:0]      f_neg_mag;
        logic [47:0]      f_pos;

        assign cur = stage_reg[j];
        assign cf  = coefs[tsel(cur.bond_type)];

        assign sq_try  = {1'b0, cur.r, 2'b01};
        assign sq_sh   = {cur.sq_rem[32:0], cur.sq_x[63:62]};
        assign sq_ge   = (sq_sh >= sq_try);
        assign pf_sh   = {cur.pf_rem[39:0], cur.pf_n[63]};
        assign pf_ge   = (pf_sh >= {1'b0, cur.s});
        assign kp2_sh  = {cur.kp2_rem[31:0], cur.kp2_n[46]};
        assign kp2_ge  = (kp2_sh >= {1'b0, cur.r});
        assign da_sh   = {cur.da_rem[31:0], cur.da_n[23]};
        assign da_ge   = (da_sh >= {1'b0, cf.rest_length});
        assign inv_sh  = {cur.inv_rem[48:0], ((j == INV0) ? 1'b1 : 1'b0)};
        assign inv_ge  = (inv_sh >= cur.dd);
        assign e1_sh   = {cur.e1_rem[24:0], cur.e1_s[46]};
        assign e1_ge   = (e1_sh >= {1'b0, cur.d});
        assign fn_sh   = {cur.fn_rem[31:0], cur.fn_s[47]};
        assign fn_ge   = (fn_sh >= {1'b0, cur.r});
        assign kg_sum  = 114'(cur.kg0) + (114'(cur.kg1) << 25)
                       + (114'(cur.kg2) << 32) + (114'(cur.kg3) << 57);
        assign tk_sum  = 104'(cur.tk0) + (104'(cur.tk1) << 24) + (104'(cur.tk2) << 48);
        assign e_sum   = {1'b0, cur.e1_q} + {1'b0, cur.kp2_q};
        assign pf_x    = 88'(cur.pf_q);
        assign f_neg_mag = (cur.fn_ovf || (cur.fn_q > wpbfe_pkg::NEG_MAG))
                         ? wpbfe_pkg::NEG_MAG : cur.fn_q;
        assign f_pos   = (cur.fn_ovf || cur.fn_q[47]) ? wpbfe_pkg::POS_MAX : cur.fn_q;

        always_comb begin
            nxt = cur;
            // square root of s * 2^24, two radicand bits per step
            if (j >= SQ0 && j < SQ0 + SQ_N) begin
                nxt.sq_rem = sq_ge ? (sq_sh - sq_try) : sq_sh;
                nxt.r      = {cur.r[30:0], sq_ge};
                nxt.sq_x   = {cur.sq_x[61:0], 2'b00};
            end
            // repulsion over squared length
            if (j >= PF0 && j < PF0 + PF_N) begin
                nxt.pf_rem = pf_ge ? (pf_sh - {1'b0, cur.s}) : pf_sh;
                nxt.pf_q   = {cur.pf_q[62:0], pf_ge};
                nxt.pf_n   = {cur.pf_n[62:0], 1'b0};
            end
            if (j == MUL_R) begin
                nxt.prod_a = 64'(cur.r) * 64'(cf.extension_ratio);
                nxt.kr     = 64'(cur.r) * 64'(cf.stiffness);
            end
            if (j == KP2_SET) begin
                nxt.kp2_ovf = (32'(cf.repulsion[31:15]) >= cur.r);
                nxt.kp2_rem = 33'(cf.repulsion[31:15]);
                nxt.kp2_n   = {cf.repulsion[14:0], 32'd0};
                nxt.kp2_q   = '0;
            end
            if (j >= KP2_0 && j < KP2_0 + KP2_N) begin
                nxt.kp2_rem = kp2_ge ? (kp2_sh - {1'b0, cur.r}) : kp2_sh;
                nxt.kp2_q   = {cur.kp2_q[45:0], kp2_ge};
                nxt.kp2_n   = {cur.kp2_n[45:0], 1'b0};
            end
            // ratio at or beyond one when the integer part reaches rest length
            if (j == DA_SET) begin
                nxt.a_sat  = (cur.prod_a[63:24] >= 40'(cf.rest_length));
                nxt.da_rem = {1'b0, cur.prod_a[55:24]};
                nxt.da_n   = cur.prod_a[23:0];
                nxt.a      = '0;
            end
            if (j >= DA0 && j < DA0 + DA_N) begin
                nxt.da_rem = da_ge ? (da_sh - {1'b0, cf.rest_length}) : da_sh;
                nxt.a      = {cur.a[22:0], da_ge};
                nxt.da_n   = {cur.da_n[22:0], 1'b0};
            end
            if (j == D1) begin
                nxt.d  = ONE_Q24 - {1'b0, cur.a};
                nxt.gm = THREE_Q24 - {1'b0, cur.a, 1'b0};
            end
            if (j == D2) begin
                nxt.dd = 50'(cur.d) * 50'(cur.d);
                nxt.g  = 50'(cur.a) * 50'(cur.gm);
            end
            if (j == KG_MUL) begin
                nxt.kg0 = 57'(cur.kr[31:0])  * 57'(cur.g[24:0]);
                nxt.kg1 = 57'(cur.kr[31:0])  * 57'(cur.g[49:25]);
                nxt.kg2 = 57'(cur.kr[63:32]) * 57'(cur.g[24:0]);
                nxt.kg3 = 57'(cur.kr[63:32]) * 57'(cur.g[49:25]);
            end
            // 2^70 / d^2
            if (j >= INV0 && j < INV0 + INV_N) begin
                nxt.inv_rem = inv_ge ? (inv_sh - cur.dd) : inv_sh;
                nxt.inv_q   = {cur.inv_q[69:0], inv_ge};
            end
            if (j == KG_SUM) begin
                nxt.e1_n = kg_sum[113:42];
            end
            if (j == E1_SET) begin
                nxt.e1_ovf = (cur.e1_n[71:47] >= cur.d);
                nxt.e1_rem = {1'b0, cur.e1_n[71:47]};
                nxt.e1_s   = cur.e1_n[46:0];
                nxt.e1_q   = '0;
            end
            if (j >= E1_0 && j < E1_0 + E1_N) begin
                nxt.e1_rem = e1_ge ? (e1_sh - {1'b0, cur.d}) : e1_sh;
                nxt.e1_q   = {cur.e1_q[45:0], e1_ge};
                nxt.e1_s   = {cur.e1_s[45:0], 1'b0};
            end
            if (j == ESUM) begin
                nxt.energy = (cur.e1_ovf || cur.kp2_ovf || e_sum[47])
                           ? wpbfe_pkg::POS_MAX : e_sum;
            end
            if (j == TT) begin
                nxt.tt = cur.inv_q + 71'(cur.a) - QUARTER;
            end
            if (j == TK_MUL) begin
                nxt.tk0 = 56'(cur.tt[23:0])  * 56'(cf.stiffness);
                nxt.tk1 = 56'(cur.tt[47:24]) * 56'(cf.stiffness);
                nxt.tk2 = 56'(cur.tt[70:48]) * 56'(cf.stiffness);
            end
            if (j == W_SUM) begin
                nxt.w = tk_sum[103:16];
            end
            if (j == NUM) begin
                nxt.fn_neg = (cur.w > pf_x);
                nxt.num    = (cur.w > pf_x) ? (cur.w - pf_x) : (pf_x - cur.w);
            end
            if (j == FN_SET) begin
                nxt.fn_ovf = (cur.num[87:24] >= 64'(cur.r));
                nxt.fn_rem = {1'b0, cur.num[55:24]};
                nxt.fn_s   = {cur.num[23:0], 24'd0};
                nxt.fn_q   = '0;
            end
            if (j >= FN0 && j < FN0 + FN_N) begin
                nxt.fn_rem = fn_ge ? (fn_sh - {1'b0, cur.r}) : fn_sh;
                nxt.fn_q   = {cur.fn_q[46:0], fn_ge};
                nxt.fn_s   = {cur.fn_s[46:0], 1'b0};
            end
            if (j == FIN) begin
                if (cur.zero) begin
                    nxt.force_q = '0;
                    nxt.energy  = wpbfe_pkg::POS_MAX;
                    nxt.status  = wpbfe_pkg::ST_ZERO;
                end else if (cur.a_sat) begin
                    nxt.force_q = wpbfe_pkg::NEG_MAG;
                    nxt.energy  = wpbfe_pkg::POS_MAX;
                    nxt.status  = wpbfe_pkg::ST_RANGE;
                end else begin
                    nxt.force_q = cur.fn_neg ? (48'd0 - f_neg_mag) : f_pos;
                    nxt.status  = wpbfe_pkg::ST_OK;
                end
            end
        end

        assign stage_next[j] = nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NSTEP; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < NSTEP; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= cap_next;
            for (int k = 0; k < NSTEP; k++) begin
                stage_reg[k+1] <= stage_next[k];
            end
        end
    end

    assign out_valid                  = vld_reg[NSTEP];
    assign out_data.force_over_length = signed'(stage_reg[NSTEP].force_q);
    assign out_data.bond_energy       = signed'(stage_reg[NSTEP].energy);
    assign out_data.status            = stage_reg[NSTEP].status;

endmodule
`default_nettype wire

// ===== sim/wlc_pow_bond_force_energy_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_pow_bond_force_energy_top_test
// Streams bonds through the force/energy unit under several coefficient sets
// and handshake idling patterns, and checks every result against an exact
// integer prediction of force over length, energy and status.
// ----------------------------------------------------------------------------
module wlc_pow_bond_force_energy_top_test;

    localparam int LATENCY_WAIT = 220;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [127:0] ONE_Q24 = 128'd1 << 24;
    localparam logic [127:0] LEN_MAX = (128'd1 << wpbfe_pkg::LEN_W) - 128'd1;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    wpbfe_pkg::in_t                   s_data = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    wpbfe_pkg::out_t                  m_data;
    logic                             cfg_we = 1'b0;
    logic [wpbfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wpbfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    wpbfe_pkg::coef_t  coef_set [2];
    wpbfe_pkg::in_t    bond_queue [$];
    wpbfe_pkg::out_t   result_queue [$];
    int     idle_mode = 0;
    int     mismatches = 0;
    int     results_seen = 0;
    int     cycles = 0;
    int     range_hits = 0;

    wlc_pow_bond_force_energy_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic wpbfe_pkg::out_t bond_result(wpbfe_pkg::in_t bond);
        wpbfe_pkg::out_t  res;
        wpbfe_pkg::coef_t c;
        logic [127:0] sq, r, a, d, inv, tt, w, p, num, g, e1;
        logic         neg;
        c  = coef_set[bond.bond_type];
        sq = 128'(bond.squared_length);
        if (sq == 0) begin
            res.force_over_length = '0;
            res.bond_energy       = wpbfe_pkg::POS_MAX;
            res.status            = wpbfe_pkg::ST_ZERO;
            return res;
        end
        r = 128'(int_sqrt(64'(sq) << 24));
        a = (c.rest_length == 0) ? ONE_Q24 : (r * c.extension_ratio) / c.rest_length;
        if (a >= ONE_Q24) begin
            res.force_over_length = wpbfe_pkg::NEG_MAG;
            res.bond_energy       = wpbfe_pkg::POS_MAX;
            res.status            = wpbfe_pkg::ST_RANGE;
            return res;
        end
        d   = ONE_Q24 - a;
        inv = (128'd1 << 70) / (d * d);
        tt  = inv + a - (128'd1 << 22);
        w   = (tt * c.stiffness) >> 16;
        p   = (128'(c.repulsion) << 32) / sq;
        neg = w > p;
        num = neg ? w - p : p - w;
        num = (num << 24) / r;
        if (neg)
            res.force_over_length = -((num > wpbfe_pkg::NEG_MAG) ? wpbfe_pkg::NEG_MAG
                                                                 : num[wpbfe_pkg::RES_W-1:0]);
        else
            res.force_over_length = (num > wpbfe_pkg::POS_MAX) ? wpbfe_pkg::POS_MAX
                                                               : num[wpbfe_pkg::RES_W-1:0];
        g  = a * (3 * ONE_Q24 - 2 * a);
        e1 = ((((128'(c.stiffness) * r) * g) >> 42) / d) + ((128'(c.repulsion) << 32) / r);
        res.bond_energy = (e1 > wpbfe_pkg::POS_MAX) ? wpbfe_pkg::POS_MAX
                                                    : e1[wpbfe_pkg::RES_W-1:0];
        res.status      = wpbfe_pkg::ST_OK;
        return res;
    endfunction

    // driver: payload only moves once the current transfer is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) result_queue.push_back(bond_result(s_data));
            if (bond_queue.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 51) ||
                  (idle_mode == 3 && $urandom_range(99) < 6))) begin
                s_data  <= bond_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (result_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", m_data);
                end else begin
                    wpbfe_pkg::out_t want;
                    want = result_queue.pop_front();
                    if (m_data.status == wpbfe_pkg::ST_RANGE) range_hits <= range_hits + 1;
                    if (m_data.force_over_length !== want.force_over_length ||
                        m_data.bond_energy !== want.bond_energy ||
                        m_data.status !== want.status) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: want f=%h e=%h st=%0d got f=%h e=%h st=%0d",
                                     want.force_over_length, want.bond_energy, want.status,
                                     m_data.force_over_length, m_data.bond_energy,
                                     m_data.status);
                    end
                end
            end
            m_ready <= !((idle_mode == 2 && $urandom_range(99) < 51) ||
                         (idle_mode == 3 && $urandom_range(99) < 6));
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("wlc_pow_bond_force_energy_top_test NOT OK");
            $finish;
        end
    end

    task automatic write_coef(logic t, wpbfe_pkg::field_t fld, logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= {t, fld};
        cfg_data  <= value;
        case (fld)
            wpbfe_pkg::FLD_STIFFNESS:   coef_set[t].stiffness       = value;
            wpbfe_pkg::FLD_REST_LENGTH: coef_set[t].rest_length     = value;
            wpbfe_pkg::FLD_EXT_RATIO:   coef_set[t].extension_ratio = value;
            default:                    coef_set[t].repulsion       = value;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_type(logic t, logic [31:0] k, logic [31:0] r0, logic [31:0] a0,
                             logic [31:0] kp);
        write_coef(t, wpbfe_pkg::FLD_STIFFNESS, k);
        write_coef(t, wpbfe_pkg::FLD_REST_LENGTH, r0);
        write_coef(t, wpbfe_pkg::FLD_EXT_RATIO, a0);
        write_coef(t, wpbfe_pkg::FLD_REPULSION, kp);
    endtask

    task automatic drain();
        wait (bond_queue.size() == 0 && !s_valid && result_queue.size() == 0);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    // mostly lengths inside the allowed extension, some anywhere in range
    task automatic queue_random(int count);
        wpbfe_pkg::in_t b;
        logic [127:0]   lm, smax;
        repeat (count) begin
            b.bond_type = 1'($urandom_range(1));
            if (coef_set[b.bond_type].extension_ratio == 0)
                lm = 128'd1 << 40;
            else
                lm = (128'(coef_set[b.bond_type].rest_length) << 24) /
                     coef_set[b.bond_type].extension_ratio;
            smax = (lm * lm) >> 24;
            if (smax > LEN_MAX) smax = LEN_MAX;
            if (smax < 2) smax = 128'd2;
            case ($urandom_range(9))
                0, 1:    b.squared_length = 40'({$urandom, $urandom});
                2:       b.squared_length = 40'({$urandom, $urandom} >> $urandom_range(39));
                3:       b.squared_length = 40'(smax - 128'($urandom_range(3)));
                default: b.squared_length = 40'(128'd1 +
                                                (128'({$urandom, $urandom}) % (smax - 128'd1)));
            endcase
            bond_queue.push_back(b);
        end
    endtask

    initial begin
        wpbfe_pkg::in_t b;
        coef_set[0] = '{32'd0, wpbfe_pkg::REST_LENGTH_RST, wpbfe_pkg::EXT_RATIO_RST, 32'd0};
        coef_set[1] = coef_set[0];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset coefficients: zero stiffness and repulsion
        foreach (coef_set[t]) begin
            b.bond_type = 1'(t);
            b.squared_length = 40'd0;          bond_queue.push_back(b);
            b.squared_length = 40'd1;          bond_queue.push_back(b);
            b.squared_length = 40'd3000000;    bond_queue.push_back(b);
            b.squared_length = 40'hFF_FFFF_FFFF; bond_queue.push_back(b);
        end
        drain();

        // directed: typical coefficients, lengths up to and past the limit
        load_type(1'b0, 32'h0001_0000, 32'h0001_0000, 32'd144179, 32'h0000_1000);
        load_type(1'b1, 32'h0003_8000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0001);
        foreach (coef_set[t]) begin
            b.bond_type = 1'(t);
            b.squared_length = 40'd0;            bond_queue.push_back(b);
            b.squared_length = 40'd1;            bond_queue.push_back(b);
            b.squared_length = 40'd1 << 20;      bond_queue.push_back(b);
            b.squared_length = 40'd3400000;      bond_queue.push_back(b);
            b.squared_length = 40'd3466000;      bond_queue.push_back(b);
            b.squared_length = 40'd1 << 24;      bond_queue.push_back(b);
            b.squared_length = 40'd60000000;     bond_queue.push_back(b);
            b.squared_length = 40'hFF_FFFF_FFFF; bond_queue.push_back(b);
            b.squared_length = 40'hAA_AAAA_AAAA; bond_queue.push_back(b);
        end
        queue_random(120);
        drain();

        // extremes: zero rest length, zero ratio, maximal coefficients
        idle_mode = 1;
        load_type(1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_type(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        queue_random(120);
        drain();

        idle_mode = 2;
        load_type(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'd1, 32'd0);
        load_type(1'b1, 32'h0010_0000, 32'h0000_8000, 32'h0000_C000, 32'h0001_0000);
        queue_random(120);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            for (int t = 0; t < 2; t++)
                load_type(1'(t), $urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                          $urandom >> $urandom_range(31), $urandom >> $urandom_range(31));
            queue_random(100);
            drain();
        end

        $display("%0d bonds checked over eight coefficient sets and four idling patterns",
                 results_seen);
        $display("%0d of them beyond the maximum extension", range_hits);
        if (mismatches == 0) begin
            $display("wlc_pow_bond_force_energy_top_test OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("wlc_pow_bond_force_energy_top_test NOT OK");
        end
        $finish;
    end

endmodule
